/* sv/least_refcount_contiguous_slot_alloc_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the slot allocator
// Concurrent assertion wrappers; they compile to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef LEAST_REFCOUNT_CONTIGUOUS_SLOT_ALLOC_ASSERT_SVH
`define LEAST_REFCOUNT_CONTIGUOUS_SLOT_ALLOC_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, disabled during reset
`define LRCSA_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled during reset
`define LRCSA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LRCSA_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg)
`define LRCSA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

/* sv/lrcsa_pkg.sv */
// ----------------------------------------------------------------------------
// Slot allocator package
// Default sizes, field widths and sequencer states shared by the block.
// ----------------------------------------------------------------------------
package lrcsa_pkg;

    // Default bucket geometry
    localparam int SLOTS_DEF      = 32;
    localparam int KEY_BITS_DEF   = 12;
    localparam int COUNT_BITS_DEF = 16;

    // Fixed word field widths
    localparam int INDEX_W   = 5;
    localparam int KEY_W     = 12;
    localparam int REFCNT_W  = 16;
    localparam int NEED_W    = 6;
    localparam int START_W   = 5;
    localparam int EVICT_W   = 6;
    localparam int IN_DATA_W = 40;
    localparam int OUT_DATA_W = 16;

    // Word kind carried in tuser
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_ALLOC = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FORM,
        ST_FIND,
        ST_MIN,
        ST_EVICT,
        ST_RESULT
    } state_t;

endpackage

/* sv/least_refcount_contiguous_slot_alloc.sv */
// ----------------------------------------------------------------------------
// Least-reference-count contiguous slot allocator
// Keeps one bucket of slots and frees a contiguous run by evicting entries
// with the smallest reference count.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request word; tuser is the mode (0 write, 1 allocate).
//   A write word stores valid bit, key and count of one slot; an allocate
//   word asks for slots_needed contiguous free slots. Every word returns one
//   m_axis word with start_slot and entries_evicted (both zero for writes).
//   A write goes straight to the result step. An allocate runs a grouping
//   scan over all slots and a free-run scan; while no run is long enough,
//   a minimum scan picks the entry with the least count, its slots are
//   cleared, and the free-run scan runs again. The grouping and minimum
//   scans sweep the single read port of the key/count RAM, one slot a cycle,
//   under one sequencer.
//   s_axis_tready is high only while the sequencer idles; one request is in
//   work at a time. The result register lets the next request enter while a
//   result still waits; a stalled m_axis holds the sequencer at its result
//   step. Reset clears all valid bits and the handshakes; no clearing pass.
// ----------------------------------------------------------------------------
`include "least_refcount_contiguous_slot_alloc_assert.svh"

module least_refcount_contiguous_slot_alloc
    import lrcsa_pkg::*;
#(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // slot_index[4:0], slot_valid[5], slot_key[17:6], slot_refcount[33:18],
    // slots_needed[39:34]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // mode
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // start_slot[4:0], entries_evicted[10:5], zero [15:11]
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int IDXW = $clog2(SLOTS);
    localparam int PTRW = $clog2(SLOTS + 1);
    localparam int CMPW = (PTRW > NEED_W) ? PTRW : NEED_W;
    localparam int RAMW = KEY_BITS + COUNT_BITS;

    // Input word fields
    logic                in_mode;
    logic [INDEX_W-1:0]  in_index;
    logic                in_valid;
    logic [KEY_W-1:0]    in_key;
    logic [REFCNT_W-1:0] in_refcnt;
    logic [NEED_W-1:0]   in_need;

    assign in_mode   = s_axis_tuser;
    assign in_index  = s_axis_tdata[4:0];
    assign in_valid  = s_axis_tdata[5];
    assign in_key    = s_axis_tdata[17:6];
    assign in_refcnt = s_axis_tdata[33:18];
    assign in_need   = s_axis_tdata[39:34];

    // Control registers
    state_t              state_reg, state_next;
    logic [SLOTS-1:0]    valid_reg, valid_next;
    logic [PTRW-1:0]     ptr_reg, ptr_next;
    logic [PTRW-1:0]     avail_reg, avail_next;
    logic                rd_vld_reg, rd_vld_next;
    logic                best_found_reg, best_found_next;
    logic                first_reg, first_next;
    logic [PTRW-1:0]     evict_reg, evict_next;
    logic                m_valid_reg, m_valid_next;

    // Payload registers
    logic [SLOTS-1:0]    sf_reg, sf_next;
    logic [NEED_W-1:0]   need_reg, need_next;
    logic [IDXW-1:0]     rd_idx_reg, rd_idx_next;
    logic [KEY_BITS-1:0] prev_key_reg, prev_key_next;
    logic [IDXW-1:0]     best_idx_reg, best_idx_next;
    logic [COUNT_BITS-1:0] best_cnt_reg, best_cnt_next;
    logic [PTRW-1:0]     start_reg, start_next;
    logic [START_W-1:0]  m_start_reg, m_start_next;
    logic [EVICT_W-1:0]  m_evict_reg, m_evict_next;

    // RAM interface
    logic                  ram_wr_en;
    logic [IDXW-1:0]       ram_wr_addr;
    logic [RAMW-1:0]       ram_wr_data;
    logic                  ram_rd_en;
    logic [RAMW-1:0]       ram_rd_data;
    logic [KEY_BITS-1:0]   rd_key;
    logic [COUNT_BITS-1:0] rd_cnt;

    // Sequencer conditions
    logic            in_accept;
    logic            index_ok;
    logic [IDXW-1:0] ptr_idx;
    logic [IDXW-1:0] prev_idx;
    logic            scan_end;
    logic            sweep_done;
    logic            run_found;
    logic            evict_go;
    logic            out_free;
    logic            better;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign index_ok      = (int'(in_index) < SLOTS);
    assign ptr_idx       = ptr_reg[IDXW-1:0];
    assign prev_idx      = rd_idx_reg - IDXW'(1);
    assign scan_end      = (ptr_reg == PTRW'(SLOTS));
    assign sweep_done    = scan_end && !rd_vld_reg;
    assign run_found     = (CMPW'(avail_reg) >= CMPW'(need_reg));
    assign evict_go      = !scan_end && valid_reg[ptr_idx] && (first_reg || !sf_reg[ptr_idx]);
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign rd_key        = ram_rd_data[KEY_BITS-1:0];
    assign rd_cnt        = ram_rd_data[KEY_BITS +: COUNT_BITS];
    assign better        = valid_reg[rd_idx_reg] && sf_reg[rd_idx_reg]
                           && (!best_found_reg || (rd_cnt < best_cnt_reg));

    // Key and count store
    assign ram_wr_en   = in_accept && (in_mode == MODE_WRITE) && index_ok;
    assign ram_wr_addr = IDXW'(in_index);
    assign ram_wr_data = {COUNT_BITS'(in_refcnt), KEY_BITS'(in_key)};
    assign ram_rd_en   = ((state_reg == ST_FORM) || (state_reg == ST_MIN)) && !scan_end;

    lrcsa_ram #(
        .WIDTH (RAMW),
        .DEPTH (SLOTS)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ptr_idx),
        .rd_data (ram_rd_data)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = (in_mode == MODE_ALLOC) ? ST_FORM : ST_RESULT;
                end
            end
            ST_FORM:
            begin
                if (sweep_done)
                begin
                    state_next = ST_FIND;
                end
            end
            ST_FIND:
            begin
                if (run_found)
                begin
                    state_next = ST_RESULT;
                end
                else if (scan_end)
                begin
                    state_next = ST_MIN;
                end
            end
            ST_MIN:
            begin
                if (sweep_done)
                begin
                    state_next = best_found_reg ? ST_EVICT : ST_RESULT;
                end
            end
            ST_EVICT:
            begin
                if (!evict_go)
                begin
                    state_next = ST_FIND;
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        valid_next      = valid_reg;
        sf_next         = sf_reg;
        ptr_next        = ptr_reg;
        avail_next      = avail_reg;
        rd_vld_next     = ram_rd_en;
        rd_idx_next     = ptr_idx;
        prev_key_next   = prev_key_reg;
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        best_cnt_next   = best_cnt_reg;
        first_next      = first_reg;
        evict_next      = evict_reg;
        start_next      = start_reg;
        need_next       = need_reg;
        m_valid_next    = m_valid_reg && !m_axis_tready;
        m_start_next    = m_start_reg;
        m_evict_next    = m_evict_reg;

        case (state_reg)
            ST_IDLE:
            begin
                // Take a request word
                if (in_accept)
                begin
                    ptr_next   = '0;
                    evict_next = '0;
                    start_next = '0;
                    need_next  = in_need;
                    if ((in_mode == MODE_WRITE) && index_ok)
                    begin
                        valid_next[IDXW'(in_index)] = in_valid;
                    end
                end
            end
            ST_FORM:
            begin
                // Mark the first slot of every entry
                if (rd_vld_reg)
                begin
                    sf_next[rd_idx_reg] = valid_reg[rd_idx_reg]
                        && ((rd_idx_reg == '0) || !valid_reg[prev_idx]
                            || (prev_key_reg != rd_key));
                    prev_key_next = rd_key;
                end
                if (ram_rd_en)
                begin
                    ptr_next = ptr_reg + PTRW'(1);
                end
                if (sweep_done)
                begin
                    ptr_next   = '0;
                    avail_next = '0;
                end
            end
            ST_FIND:
            begin
                // Walk the valid bits for a long enough free run
                if (run_found)
                begin
                    start_next = ptr_reg - avail_reg;
                end
                else if (scan_end)
                begin
                    ptr_next        = '0;
                    best_found_next = 1'b0;
                end
                else
                begin
                    avail_next = valid_reg[ptr_idx] ? '0 : (avail_reg + PTRW'(1));
                    ptr_next   = ptr_reg + PTRW'(1);
                end
            end
            ST_MIN:
            begin
                // Track the live entry with the least count, lowest slot on ties
                if (rd_vld_reg && better)
                begin
                    best_found_next = 1'b1;
                    best_idx_next   = rd_idx_reg;
                    best_cnt_next   = rd_cnt;
                end
                if (ram_rd_en)
                begin
                    ptr_next = ptr_reg + PTRW'(1);
                end
                if (sweep_done)
                begin
                    if (best_found_reg)
                    begin
                        ptr_next   = PTRW'(best_idx_reg);
                        first_next = 1'b1;
                        evict_next = evict_reg + PTRW'(1);
                    end
                    else
                    begin
                        start_next = '0;
                    end
                end
            end
            ST_EVICT:
            begin
                // Drop the slots of the chosen entry
                if (evict_go)
                begin
                    valid_next[ptr_idx] = 1'b0;
                    ptr_next            = ptr_reg + PTRW'(1);
                    first_next          = 1'b0;
                end
                else
                begin
                    ptr_next   = '0;
                    avail_next = '0;
                end
            end
            ST_RESULT:
            begin
                // Load the result register once it is free
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_start_next = START_W'(start_reg);
                    m_evict_next = EVICT_W'(evict_reg);
                end
            end
            default:
            begin
                m_valid_next = m_valid_reg && !m_axis_tready;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            ptr_reg        <= '0;
            avail_reg      <= '0;
            rd_vld_reg     <= 1'b0;
            best_found_reg <= 1'b0;
            first_reg      <= 1'b0;
            evict_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            ptr_reg        <= ptr_next;
            avail_reg      <= avail_next;
            rd_vld_reg     <= rd_vld_next;
            best_found_reg <= best_found_next;
            first_reg      <= first_next;
            evict_reg      <= evict_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        sf_reg       <= sf_next;
        need_reg     <= need_next;
        rd_idx_reg   <= rd_idx_next;
        prev_key_reg <= prev_key_next;
        best_idx_reg <= best_idx_next;
        best_cnt_reg <= best_cnt_next;
        start_reg    <= start_next;
        m_start_reg  <= m_start_next;
        m_evict_reg  <= m_evict_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - START_W - EVICT_W){1'b0}}, m_evict_reg, m_start_reg};

    // Checks
    `LRCSA_ASSERT_NEXT(a_result_loads, clk, rst_n, (state_reg == ST_RESULT) && out_free, m_valid_reg && (state_reg == ST_IDLE), "result not loaded when output free")
    `LRCSA_ASSERT_NOW(a_evict_head, clk, rst_n, (state_reg == ST_EVICT) && first_reg, !scan_end && valid_reg[ptr_idx] && sf_reg[ptr_idx], "eviction does not start at a live entry head")
    `LRCSA_ASSERT_NOW(a_evict_bound, clk, rst_n, 1'b1, evict_reg <= PTRW'(SLOTS), "eviction count exceeds slot count")
    `LRCSA_ASSERT_NEXT(a_evict_clears, clk, rst_n, (state_reg == ST_EVICT) && evict_go, !valid_reg[$past(ptr_idx)], "evicted slot still valid")

endmodule

/* sv/lrcsa_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lrcsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
